// File: design/bounded_sequence_list_core_assert.svh
// Assertion macros for the checker of the bounded sequence list.
// Needs nothing else; every macro expands to one labeled concurrent assertion.
`ifndef BOUNDED_SEQUENCE_LIST_CORE_ASSERT_SVH
`define BOUNDED_SEQUENCE_LIST_CORE_ASSERT_SVH

// Same-cycle implication, disabled while rst_n is low.
`define BSL_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while rst_n is low.
`define BSL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/bsl_pkg.sv
// Package for the bounded sequence list: widths, operation and status codes,
// controller states and the command/status structs. Depends on nothing.
`default_nettype none

package bsl_pkg;

    // Default number of stored values.
    localparam int CAPACITY_DEF = 16;

    // Field widths.
    localparam int OP_W      = 3;
    localparam int DATA_W    = 32;
    localparam int POS_W     = 8;
    localparam int STAT_W    = 2;
    localparam int LEN_W     = 5;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    // Operation codes; the spare code leaves the list unchanged and returns ST_OK.
    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_DEL_FIRST = 3'd2,
        OP_DEL_LAST  = 3'd3,
        OP_DEL_POS   = 3'd4,
        OP_COUNT     = 3'd5,
        OP_DUMP      = 3'd6
    } op_t;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADPOS = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_DUMP = 2'd2
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;    // latch the incoming item
        logic exec;       // carry out the latched operation
        logic dump_step;  // emit the front entry and rotate the list
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;   // output register can take a result this cycle
        logic dump_walk;  // latched item is a dump of a non-empty list
        logic rem_last;   // the next dump result is the final one
    } stat_t;

endpackage

`default_nettype wire

// File: design/bsl_ctrl.sv
// Controller of the bounded sequence list: a three-state machine that
// sequences capture, execution and the dump walk. Uses bsl_pkg.
`default_nettype none

module bsl_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire bsl_pkg::stat_t st,
    output bsl_pkg::cmd_t       cmd
);
    import bsl_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (st.dump_walk) begin
                    state_next = S_DUMP;
                end else if (st.out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_DUMP: begin
                if (st.out_free && st.rem_last) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output logic.
    always_comb begin
        s_tready      = 1'b0;
        cmd.capture   = 1'b0;
        cmd.exec      = 1'b0;
        cmd.dump_step = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            S_EXEC: begin
                // A dump walk emits nothing here, so it need not wait.
                cmd.exec = st.dump_walk || st.out_free;
            end
            S_DUMP: begin
                cmd.dump_step = st.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: design/bsl_dpath.sv
// Datapath of the bounded sequence list: item registers, the shifting entry
// array, the entry count, the dump counter and the output register. Uses bsl_pkg.
`default_nettype none

module bsl_dpath #(
    parameter int CAPACITY = bsl_pkg::CAPACITY_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire bsl_pkg::cmd_t               cmd,
    output bsl_pkg::stat_t                   st,
    input  wire logic [bsl_pkg::OP_W-1:0]    in_op,
    input  wire logic [bsl_pkg::DATA_W-1:0]  in_value,
    input  wire logic [bsl_pkg::POS_W-1:0]   in_position,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output bsl_pkg::status_t                 out_status,
    output logic [bsl_pkg::DATA_W-1:0]       out_data,
    output logic [bsl_pkg::LEN_W-1:0]        out_length,
    output logic                             out_last
);
    import bsl_pkg::*;

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int IW    = $clog2(CAPACITY);
    localparam int CMP_W = (CW > POS_W) ? CW : POS_W;

    // Latched item.
    op_t               op_reg;
    logic [DATA_W-1:0] value_reg;
    logic [POS_W-1:0]  pos_reg;

    // List state.
    logic [DATA_W-1:0] entries_reg [CAPACITY];
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [CW-1:0]     rem_reg;
    logic [CW-1:0]     rem_next;

    // Output register.
    logic              valid_reg;
    logic              valid_next;
    status_t           status_reg;
    logic [DATA_W-1:0] data_reg;
    logic [LEN_W-1:0]  len_reg;
    logic              last_reg;

    // Decode of the latched operation.
    logic          empty_w;
    logic          full_w;
    logic          pos_ok_w;
    logic          ins_front_w;
    logic          ins_back_w;
    logic          del_w;
    logic          dec_w;
    logic [IW-1:0] del_idx_w;
    status_t       status_w;
    logic          emit_w;

    // Capture the input item.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg    <= op_t'(in_op);
            value_reg <= in_value;
            pos_reg   <= in_position;
        end
    end

    assign empty_w  = (count_reg == '0);
    assign full_w   = (count_reg >= CW'(CAPACITY));
    assign pos_ok_w = !pos_reg[POS_W-1] && (CMP_W'(pos_reg) < CMP_W'(count_reg));

    // Operation decode: which array move and which status.
    always_comb begin
        ins_front_w = 1'b0;
        ins_back_w  = 1'b0;
        del_w       = 1'b0;
        dec_w       = 1'b0;
        del_idx_w   = '0;
        status_w    = ST_OK;
        case (op_reg)
            OP_INS_FRONT: begin
                if (full_w) status_w = ST_FULL;
                else ins_front_w = 1'b1;
            end
            OP_INS_BACK: begin
                if (full_w) status_w = ST_FULL;
                else ins_back_w = 1'b1;
            end
            OP_DEL_FIRST: begin
                if (empty_w) begin
                    status_w = ST_EMPTY;
                end else begin
                    del_w = 1'b1;
                    dec_w = 1'b1;
                end
            end
            OP_DEL_LAST: begin
                if (empty_w) status_w = ST_EMPTY;
                else dec_w = 1'b1;
            end
            OP_DEL_POS: begin
                del_idx_w = IW'(pos_reg);
                if (empty_w) begin
                    status_w = ST_EMPTY;
                end else if (!pos_ok_w) begin
                    status_w = ST_BADPOS;
                end else begin
                    del_w = 1'b1;
                    dec_w = 1'b1;
                end
            end
            OP_DUMP: begin
                if (empty_w) status_w = ST_EMPTY;
            end
            default: begin
                status_w = ST_OK;
            end
        endcase
    end

    assign st.out_free  = !valid_reg || out_ready;
    assign st.dump_walk = (op_reg == OP_DUMP) && !empty_w;
    assign st.rem_last  = (rem_reg == CW'(1));
    assign emit_w       = cmd.exec && !st.dump_walk;

    // Entry cells: each takes its own value, a neighbor, the front entry or
    // the inserted value.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_W-1:0] right_w;
        logic [DATA_W-1:0] left_w;
        logic [DATA_W-1:0] cell_next;

        if (g < CAPACITY - 1) begin : g_right
            assign right_w = entries_reg[g+1];
        end else begin : g_edge_r
            assign right_w = entries_reg[g];
        end

        if (g > 0) begin : g_left
            assign left_w = entries_reg[g-1];
        end else begin : g_edge_l
            assign left_w = value_reg;
        end

        always_comb begin
            cell_next = entries_reg[g];
            if (cmd.exec && ins_front_w) begin
                cell_next = left_w;
            end else if (cmd.exec && ins_back_w && (count_reg == CW'(g))) begin
                cell_next = value_reg;
            end else if (cmd.exec && del_w && (IW'(g) >= del_idx_w)) begin
                cell_next = right_w;
            end else if (cmd.dump_step) begin
                // Rotate the stored entries by one toward the front.
                if (CW'(g + 1) < count_reg) begin
                    cell_next = right_w;
                end else if (CW'(g + 1) == count_reg) begin
                    cell_next = entries_reg[0];
                end
            end
        end

        always_ff @(posedge aclk) begin
            entries_reg[g] <= cell_next;
        end
    end

    // Entry count and dump counter.
    always_comb begin
        count_next = count_reg;
        if (cmd.exec && (ins_front_w || ins_back_w)) begin
            count_next = count_reg + CW'(1);
        end else if (cmd.exec && dec_w) begin
            count_next = count_reg - CW'(1);
        end
        rem_next = rem_reg;
        if (cmd.exec && st.dump_walk) begin
            rem_next = count_reg;
        end else if (cmd.dump_step) begin
            rem_next = rem_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            rem_reg   <= '0;
        end else begin
            count_reg <= count_next;
            rem_reg   <= rem_next;
        end
    end

    // Output register.
    always_comb begin
        valid_next = valid_reg;
        if (emit_w || cmd.dump_step) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_w) begin
            status_reg <= status_w;
            data_reg   <= '0;
            len_reg    <= LEN_W'(count_next);
            last_reg   <= 1'b1;
        end else if (cmd.dump_step) begin
            status_reg <= ST_OK;
            data_reg   <= entries_reg[0];
            len_reg    <= LEN_W'(count_reg);
            last_reg   <= st.rem_last;
        end
    end

    assign out_valid  = valid_reg;
    assign out_status = status_reg;
    assign out_data   = data_reg;
    assign out_length = len_reg;
    assign out_last   = last_reg;

endmodule

`default_nettype wire

// File: design/bounded_sequence_list_core.sv
// Bounded sequence list: an ordered list of up to CAPACITY signed 32-bit values.
// Input item: s_tuser = operation, s_tdata = value and delete position.
// Result item: m_tuser = status, m_tdata = data and length, m_tlast ends an item.
// Every operation gives one result; a dump of a non-empty list gives one result
// per entry, front first, with m_tlast on the back entry.
// An item is taken in the idle state and executed in the execute state; the output
// register then drives m_tvalid. For a dump, the execute state loads the dump
// counter and the dump state emits one entry per cycle while the receiver does not
// stall, as the entry array rotates by one position toward the front for each result.
// s_tready is high in the idle state only, so items are taken one at a time.
// The output register holds one result: while the receiver stalls, a new item
// is still taken, but its result waits until the held result is taken.
// Reset (aresetn low, synchronous) empties the list and drops any pending
// result; entry contents are not cleared.
// Uses bsl_pkg, bsl_ctrl and bsl_dpath.
`default_nettype none

module bounded_sequence_list_core #(
    parameter int CAPACITY = bsl_pkg::CAPACITY_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // [31:0] value, [39:32] position
    input  wire logic [bsl_pkg::S_TDATA_W-1:0]  s_tdata,
    // [2:0] op
    input  wire logic [bsl_pkg::OP_W-1:0]       s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [31:0] data, [36:32] length, [39:37] zero
    output logic [bsl_pkg::M_TDATA_W-1:0]       m_tdata,
    // [1:0] status
    output logic [bsl_pkg::STAT_W-1:0]          m_tuser,
    output logic                                m_tlast
);
    import bsl_pkg::*;

    cmd_t              cmd;
    stat_t             st;
    status_t           out_status;
    logic [DATA_W-1:0] out_data;
    logic [LEN_W-1:0]  out_length;

    // Controller.
    bsl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    // Datapath.
    bsl_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .st          (st),
        .in_op       (s_tuser),
        .in_value    (s_tdata[DATA_W-1:0]),
        .in_position (s_tdata[DATA_W +: POS_W]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_status  (out_status),
        .out_data    (out_data),
        .out_length  (out_length),
        .out_last    (m_tlast)
    );

    // Result packing.
    assign m_tuser = out_status;
    assign m_tdata = {{(M_TDATA_W - DATA_W - LEN_W){1'b0}}, out_length, out_data};

endmodule

`default_nettype wire

// File: design/bsl_checker.sv
// Port-level checker for the bounded sequence list, bound to the top level.
// Uses bsl_pkg and the assertion macros of bounded_sequence_list_core_assert.svh.
`default_nettype none

`include "bounded_sequence_list_core_assert.svh"

module bsl_checker #(
    parameter int CAPACITY = bsl_pkg::CAPACITY_DEF
) (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [bsl_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic [bsl_pkg::STAT_W-1:0]    m_tuser,
    input wire logic                          m_tlast
);
    import bsl_pkg::*;

    // A stalled result keeps its payload.
    `BSL_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

    // Reset drops any pending result.
    `BSL_ASSERT_NEXT(a_reset_empty, aclk, 1'b1, !aresetn, !m_tvalid, "result valid after reset")

    // One item at a time: no new item is taken in the cycle after acceptance.
    `BSL_ASSERT_NEXT(a_one_item, aclk, aresetn, s_tvalid && s_tready, !s_tready, "input taken in execute cycle")

    // An error status is a single closing result with zero data.
    `BSL_ASSERT_IMPLY(a_err_result, aclk, aresetn, m_tvalid && (m_tuser != ST_OK), m_tlast && (m_tdata[DATA_W-1:0] == '0), "error result malformed")

    // The reported length never exceeds the capacity.
    `BSL_ASSERT_IMPLY(a_len_bound, aclk, aresetn, m_tvalid, (CAPACITY > 31) || (m_tdata[DATA_W +: LEN_W] <= LEN_W'(CAPACITY)), "length beyond capacity")

endmodule

bind bounded_sequence_list_core bsl_checker #(
    .CAPACITY (CAPACITY)
) u_bsl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
